/* rtl/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the flywheel PID settle loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int unsigned MV_PER_PCT  = 120;
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned MV_PER_VOLT = 1000;
  localparam int unsigned DRIVE_LIMIT = 12;
  localparam int unsigned Q_FRAC      = 20;

  localparam logic [6:0]  TARGET_RST = 7'd0;
  localparam logic [23:0] GAIN_P_RST = 24'd104858;
  localparam logic [23:0] GAIN_I_RST = 24'd209715;
  localparam logic [23:0] GAIN_D_RST = 24'd52;
  localparam logic [6:0]  MARGIN_RST = 7'd2;

  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CFG_TARGET = 3'd0,
    CFG_GAIN_P = 3'd1,
    CFG_GAIN_I = 3'd2,
    CFG_GAIN_D = 3'd3,
    CFG_MARGIN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]  target_pct;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [6:0]  margin_pct;
  } cfg_t;

  // error stage result
  typedef struct packed {
    logic signed [15:0] err;
    logic signed [31:0] sum;
    logic signed [16:0] deriv;
    logic               skip;
    logic               settled;
  } err_t;

  // weighted terms
  typedef struct packed {
    logic signed [40:0] p;
    logic signed [56:0] i;
    logic signed [41:0] d;
    logic               skip;
    logic               settled;
  } prod_t;

  typedef struct packed {
    logic signed [57:0] total;
    logic               skip;
    logic               settled;
  } tot_t;

endpackage

`default_nettype wire

/* rtl/fps_cfg.sv */
// ----------------------------------------------------------------------------
// fps_cfg
// Configuration register file: target, PID gains and settle margin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  output fps_pkg::cfg_t      cfg_o
);

  fps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_pct <= fps_pkg::TARGET_RST;
      cfg_q.gain_p     <= fps_pkg::GAIN_P_RST;
      cfg_q.gain_i     <= fps_pkg::GAIN_I_RST;
      cfg_q.gain_d     <= fps_pkg::GAIN_D_RST;
      cfg_q.margin_pct <= fps_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      case (fps_pkg::cfg_idx_e'(cfg_idx_i))
        fps_pkg::CFG_TARGET: cfg_q.target_pct <= cfg_wdata_i[6:0];
        fps_pkg::CFG_GAIN_P: cfg_q.gain_p     <= cfg_wdata_i;
        fps_pkg::CFG_GAIN_I: cfg_q.gain_i     <= cfg_wdata_i;
        fps_pkg::CFG_GAIN_D: cfg_q.gain_d     <= cfg_wdata_i;
        fps_pkg::CFG_MARGIN: cfg_q.margin_pct <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/fps_err.sv */
// ----------------------------------------------------------------------------
// fps_err
// Input register, loop state (error sum, previous error, done latch) and
// the error stage register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_err (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fps_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] meas_i,
  input  logic               start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fps_pkg::err_t      out_o
);

  logic               s1_valid_q;
  logic signed [14:0] s1_meas_q;
  logic               s1_start_q;
  logic               s2_valid_q;
  fps_pkg::err_t      s2_q;
  fps_pkg::err_t      s2_d;

  logic signed [31:0] sum_q;
  logic signed [15:0] prev_q;
  logic               done_q;

  logic               s1_ready;
  logic               s2_ready;
  logic               fire;
  logic               eff_done;
  logic signed [31:0] eff_sum;
  logic signed [15:0] eff_prev;
  logic [13:0]        target_mv;
  logic signed [15:0] err;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic [14:0]        abs_err;
  logic [21:0]        err_scaled;
  logic [21:0]        band;
  logic               in_band;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign fire       = s1_valid_q && s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    eff_done  = done_q && !s1_start_q;
    eff_sum   = s1_start_q ? 32'sd0 : sum_q;
    eff_prev  = s1_start_q ? 16'sd0 : prev_q;
    target_mv = 14'(cfg_i.target_pct) * 14'(fps_pkg::MV_PER_PCT);
    err       = $signed({2'b00, target_mv}) - $signed({s1_meas_q[14], s1_meas_q});
    sum_wide  = $signed({eff_sum[31], eff_sum}) + $signed({{17{err[15]}}, err});
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? fps_pkg::SUM_MIN : fps_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[31:0];
    end
    abs_err    = err[15] ? 15'(-err) : err[14:0];
    err_scaled = 22'(abs_err) * 22'(fps_pkg::PCT_SCALE);
    band       = 22'(cfg_i.margin_pct) * 22'(target_mv);
    in_band    = err_scaled <= band;

    s2_d.err     = err;
    s2_d.sum     = sum_sat;
    s2_d.deriv   = $signed({eff_prev[15], eff_prev}) - $signed({err[15], err});
    s2_d.skip    = eff_done;
    s2_d.settled = eff_done || in_band;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sum_q      <= '0;
      prev_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (fire && !eff_done) begin
        sum_q  <= sum_sat;
        prev_q <= err;
        done_q <= in_band;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_meas_q  <= meas_i;
      s1_start_q <= start_i;
    end
    if (fire) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

`default_nettype wire

/* rtl/fps_mac.sv */
// ----------------------------------------------------------------------------
// fps_mac
// Gain multiply stage followed by the three-term sum stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_mac (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fps_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fps_pkg::err_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fps_pkg::tot_t out_o
);

  logic           s3_valid_q;
  logic           s4_valid_q;
  fps_pkg::prod_t s3_q;
  fps_pkg::prod_t s3_d;
  fps_pkg::tot_t  s4_q;
  fps_pkg::tot_t  s4_d;
  logic           s3_ready;
  logic           s4_ready;

  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  always_comb begin
    s3_d.p       = $signed({1'b0, cfg_i.gain_p}) * in_i.err;
    s3_d.i       = $signed({1'b0, cfg_i.gain_i}) * in_i.sum;
    s3_d.d       = $signed({1'b0, cfg_i.gain_d}) * in_i.deriv;
    s3_d.skip    = in_i.skip;
    s3_d.settled = in_i.settled;

    s4_d.total   = $signed({{17{s3_q.p[40]}}, s3_q.p})
                 + $signed({s3_q.i[56], s3_q.i})
                 + $signed({{16{s3_q.d[41]}}, s3_q.d});
    s4_d.skip    = s3_q.skip;
    s4_d.settled = s3_q.settled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= in_valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_q <= s3_d;
    end
    if (s4_ready && s3_valid_q) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_o       = s4_q;

endmodule

`default_nettype wire

/* rtl/fps_drive.sv */
// ----------------------------------------------------------------------------
// fps_drive
// Scales the weighted total to whole volts, saturates, holds the settled
// drive and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_drive (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fps_pkg::tot_t     in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [4:0] drive_o,
  output logic              settled_o
);

  logic              out_valid_q;
  logic signed [4:0] drive_q;
  logic              settled_q;
  logic signed [4:0] held_q;
  logic              load;
  logic              neg;
  logic [57:0]       mag_full;
  logic [37:0]       mag;
  logic [3:0]        volts;
  logic signed [4:0] drive_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_ready_o && in_valid_i;

  // truncate toward zero: work on the magnitude, restore the sign
  always_comb begin
    neg      = in_i.total[57];
    mag_full = neg ? 58'(-in_i.total) : 58'(in_i.total);
    mag      = mag_full[57:fps_pkg::Q_FRAC];
    volts    = 4'd0;
    for (int k = 1; k <= int'(fps_pkg::DRIVE_LIMIT); k++) begin
      if (mag >= 38'(k * fps_pkg::MV_PER_VOLT)) begin
        volts = 4'(k);
      end
    end
    drive_d = neg ? $signed(5'd0 - {1'b0, volts}) : $signed({1'b0, volts});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
      if (load && !in_i.skip) begin
        held_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_q   <= in_i.skip ? held_q : drive_d;
      settled_q <= in_i.settled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign settled_o   = settled_q;

endmodule

`default_nettype wire

/* rtl/flywheel_pid_settle.sv */
// ----------------------------------------------------------------------------
// flywheel_pid_settle
// PID speed loop on measured motor voltage, run until the error settles.
// Five registers in order: input, error stage, multiply, sum, drive output.
// Throughput: one sample per cycle unless out_ready_i stalls the pipeline;
// loop state (error sum, previous error, done) closes in the error stage.
// Reset: clears valids, loop state and held drive; registers take defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flywheel_pid_settle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] measured_mv_i,
  input  logic               start_run_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [4:0]  drive_volts_o,
  output logic               settled_o
);

  fps_pkg::cfg_t cfg;
  fps_pkg::err_t err_s;
  fps_pkg::tot_t tot_s;
  logic          err_valid;
  logic          err_ready;
  logic          tot_valid;
  logic          tot_ready;

  fps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fps_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .meas_i      (measured_mv_i),
    .start_i     (start_run_i),
    .out_valid_o (err_valid),
    .out_ready_i (err_ready),
    .out_o       (err_s)
  );

  fps_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (err_valid),
    .in_ready_o  (err_ready),
    .in_i        (err_s),
    .out_valid_o (tot_valid),
    .out_ready_i (tot_ready),
    .out_o       (tot_s)
  );

  fps_drive u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tot_valid),
    .in_ready_o  (tot_ready),
    .in_i        (tot_s),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_volts_o),
    .settled_o   (settled_o)
  );

endmodule

`default_nettype wire

/* rtl/fps_checker.sv */
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks for flywheel_pid_settle, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [4:0] drive_volts_o,
  input logic              settled_o
);

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_volts_o <= 5'sd12) && (drive_volts_o >= -5'sd12))
    else $error("drive outside +/-12 V");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without accepted sample");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd5)
    else $error("more samples in flight than pipeline stages");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_volts_o) && $stable(settled_o))
    else $error("stalled result changed");

endmodule

bind flywheel_pid_settle fps_checker u_fps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_volts_o (drive_volts_o),
  .settled_o     (settled_o)
);

`default_nettype wire
